>>> rtl/core/hashed_page_table_insert_sweep_assert.svh
// Assertion macros for the hashed page table insert and sweep block.
// Used by the top level; assumes clk_i and rst_ni are in scope.
`ifndef HASHED_PAGE_TABLE_INSERT_SWEEP_ASSERT_SVH
`define HASHED_PAGE_TABLE_INSERT_SWEEP_ASSERT_SVH

// same-cycle implication
`define HPT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpt assertion failed");

// next-cycle implication
`define HPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpt assertion failed");

`endif

>>> rtl/core/hpt_pkg.sv
// Shared types, constants and functions of the hashed page table block.
// No dependencies; imported by hpt_ctrl, the top level and the bench.
package hpt_pkg;

  localparam int unsigned TABLE_BITS      = 10;
  localparam int unsigned SLOTS_PER_GROUP = 8;
  localparam int unsigned SLOT_W          = $clog2(SLOTS_PER_GROUP);
  localparam int unsigned ADDR_W          = TABLE_BITS + SLOT_W;
  localparam int unsigned NUM_ENTRIES     = (1 << ADDR_W);
  localparam int unsigned CNT_W           = ADDR_W + 1;
  localparam int unsigned ENTRY_W         = 64;
  localparam int unsigned WORD_W          = 32;

  localparam int unsigned SPACE_ID_W = 21;
  localparam int unsigned VA_W       = 32;
  localparam int unsigned PHYS_W     = 32;
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned GROUP_W    = 10;
  localparam int unsigned PURGE_W    = 32;
  localparam int unsigned VSID_W     = SPACE_ID_W + 3;

  localparam int unsigned S_FIELDS_W = SPACE_ID_W + VA_W + PHYS_W + COLOR_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = STATUS_W + GROUP_W + SLOT_W + 1 + PURGE_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned GRP_LIM = (TABLE_BITS >= GROUP_W) ? GROUP_W : TABLE_BITS;
  localparam logic [GROUP_W-1:0] GROUP_MASK      = GROUP_W'((1 << GRP_LIM) - 1);
  localparam logic [GROUP_W-1:0] HASH_MASK_RESET = GROUP_W'(1023);
  localparam logic [CNT_W-1:0]   CNT_END         = CNT_W'(NUM_ENTRIES);
  localparam logic [CNT_W-1:0]   CNT_SLOTS       = CNT_W'(SLOTS_PER_GROUP);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SWEEP  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCHED = 3'd0,
    ST_FREE    = 3'd1,
    ST_VICTIM  = 3'd2,
    ST_SWEEP   = 3'd3,
    ST_REJECT  = 3'd4
  } status_e;

  typedef struct packed {
    kind_e                 kind;
    logic [SPACE_ID_W-1:0] space_id;
    logic [VA_W-1:0]       virt_addr;
    logic [PHYS_W-1:0]     phys_word;
    logic [COLOR_W-1:0]    sweep_color;
  } item_t;

  typedef struct packed {
    status_e              status;
    logic [GROUP_W-1:0]   group_index;
    logic [SLOT_W-1:0]    slot;
    logic                 tlb_flush;
    logic [PURGE_W-1:0]   purge_total;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // id times eight, or'ed with the top four address bits
  function automatic logic [VSID_W-1:0] make_vsid(logic [SPACE_ID_W-1:0] sid,
                                                  logic [VA_W-1:0] va);
    return {sid, 3'b000} | {{(VSID_W-4){1'b0}}, va[31:28]};
  endfunction

  function automatic logic [GROUP_W-1:0] hash_group(logic [SPACE_ID_W-1:0] sid,
                                                    logic [VA_W-1:0] va,
                                                    logic [GROUP_W-1:0] mask);
    logic [VSID_W-1:0] vsid;
    vsid = make_vsid(sid, va);
    return (vsid[GROUP_W-1:0] ^ va[21:12]) & mask & GROUP_MASK;
  endfunction

  function automatic logic [WORD_W-1:0] make_pte0(logic [SPACE_ID_W-1:0] sid,
                                                  logic [VA_W-1:0] va);
    return {1'b1, make_vsid(sid, va), 1'b0, va[27:22]};
  endfunction

endpackage

>>> rtl/core/hpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hpt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/hpt_ctrl.sv
// Sequencer of the hashed page table: clearing pass, group scan and write, sweep, id zero reject.
// Depends on hpt_pkg; drives the table RAM through a mem_req_t request.
module hpt_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [hpt_pkg::GROUP_W-1:0]    hash_mask_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hpt_pkg::item_t                 in_item_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output hpt_pkg::result_t               res_o,
  output hpt_pkg::mem_req_t              mem_req_o,
  input  logic [hpt_pkg::ENTRY_W-1:0]    mem_rdata_i
);
  import hpt_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_PICK  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic                matched_q, matched_d;
  logic                free_q, free_d;
  logic [SLOT_W-1:0]   victim_q, victim_d;
  logic [PURGE_W-1:0]  purge_q, purge_d;

  logic [SLOT_W-1:0]   match_slot_q, match_slot_d;
  logic [SLOT_W-1:0]   free_slot_q, free_slot_d;
  logic [SLOT_W-1:0]   chosen_q, chosen_d;
  status_e             status_q, status_d;
  logic [GROUP_W-1:0]  grp_q, grp_d;
  logic [WORD_W-1:0]   pte0_q, pte0_d;
  logic [PHYS_W-1:0]   phys_q, phys_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  result_t             res_q, res_d;

  logic [TABLE_BITS-1:0] grp_addr;
  logic [WORD_W-1:0]     rd_hi;
  logic                  flush;

  assign grp_addr = TABLE_BITS'(grp_q);
  assign rd_hi    = mem_rdata_i[ENTRY_W-1:WORD_W];
  assign flush    = (mem_rdata_i != {pte0_q, phys_q});

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    matched_d    = matched_q;
    free_d       = free_q;
    victim_d     = victim_q;
    purge_d      = purge_q;
    match_slot_d = match_slot_q;
    free_slot_d  = free_slot_q;
    chosen_d     = chosen_q;
    status_d     = status_q;
    grp_d        = grp_q;
    pte0_d       = pte0_q;
    phys_d       = phys_q;
    color_d      = color_q;
    res_d        = res_q;
    mem_req_o    = '0;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q[ADDR_W-1:0];
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_END - 1'b1) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d     = '0;
          pend_d    = 1'b0;
          matched_d = 1'b0;
          free_d    = 1'b0;
          phys_d    = in_item_i.phys_word;
          color_d   = in_item_i.sweep_color;
          grp_d     = hash_group(in_item_i.space_id, in_item_i.virt_addr, hash_mask_i);
          pte0_d    = make_pte0(in_item_i.space_id, in_item_i.virt_addr);
          if (in_item_i.kind == KIND_SWEEP) begin
            state_d = S_SWEEP;
          end else if (in_item_i.space_id == '0) begin
            res_d   = '{status: ST_REJECT, group_index: '0, slot: '0,
                        tlb_flush: 1'b0, purge_total: purge_q};
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q != CNT_SLOTS) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = {grp_addr, cnt_q[SLOT_W-1:0]};
          pend_d          = 1'b1;
          pend_addr_d     = {grp_addr, cnt_q[SLOT_W-1:0]};
          cnt_d           = cnt_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PICK;
        end
        if (pend_q) begin
          if (rd_hi == pte0_q && !matched_q) begin
            matched_d    = 1'b1;
            match_slot_d = pend_addr_q[SLOT_W-1:0];
          end
          if (!rd_hi[WORD_W-1] && !free_q) begin
            free_d      = 1'b1;
            free_slot_d = pend_addr_q[SLOT_W-1:0];
          end
        end
      end
      S_PICK: begin
        if (matched_q) begin
          chosen_d = match_slot_q;
          status_d = ST_MATCHED;
        end else if (free_q) begin
          chosen_d = free_slot_q;
          status_d = ST_FREE;
        end else begin
          chosen_d = victim_q;
          status_d = ST_VICTIM;
          victim_d = victim_q + 1'b1;
        end
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {grp_addr, chosen_d};
        state_d         = S_WRITE;
      end
      S_WRITE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {grp_addr, chosen_q};
        mem_req_o.wdata = {pte0_q, phys_q};
        purge_d         = purge_q + PURGE_W'(flush);
        res_d           = '{status: status_q, group_index: grp_q, slot: chosen_q,
                            tlb_flush: flush, purge_total: purge_d};
        state_d         = S_DONE;
      end
      S_SWEEP: begin
        if (cnt_q != CNT_END) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cnt_q[ADDR_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = cnt_q[ADDR_W-1:0];
          cnt_d           = cnt_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          res_d   = '{status: ST_SWEEP, group_index: '0, slot: '0,
                      tlb_flush: 1'b0, purge_total: purge_q};
          state_d = S_DONE;
        end
        if (pend_q && rd_hi[WORD_W-1 -: COLOR_W+1] == {1'b1, color_q}) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pend_addr_q;
          mem_req_o.wdata = {{WORD_W{1'b0}}, mem_rdata_i[WORD_W-1:0]};
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      matched_q <= 1'b0;
      free_q    <= 1'b0;
      victim_q  <= '0;
      purge_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      matched_q <= matched_d;
      free_q    <= free_d;
      victim_q  <= victim_d;
      purge_q   <= purge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    match_slot_q <= match_slot_d;
    free_slot_q  <= free_slot_d;
    chosen_q     <= chosen_d;
    status_q     <= status_d;
    grp_q        <= grp_d;
    pte0_q       <= pte0_d;
    phys_q       <= phys_d;
    color_q      <= color_d;
    res_q        <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/hashed_page_table_insert_sweep.sv
// Hashed page table insert and color sweep, top level.
// Insert: one group's eight slots are scanned through the single table RAM read
// port, the chosen slot is read and rewritten; the next item waits for the result.
// Sweep: one table entry read per cycle over all 8192 entries. Id zero: no table access.
// Reset: a clearing pass writes all 8192 entries, one per cycle, with s_axis_tready low.
// Uses hpt_pkg, hpt_ctrl, hpt_ram and hashed_page_table_insert_sweep_assert.svh.
module hashed_page_table_insert_sweep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hpt_pkg::GROUP_W-1:0]    cfg_data_i,     // hash_mask
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // space_id, virt_addr, phys_word, sweep_color
  input  logic [hpt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,   // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status, group_index, slot, tlb_flush, purge_total
  output logic [hpt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import hpt_pkg::*;

  logic [GROUP_W-1:0] hash_mask_q;
  item_t              in_item;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               m_valid_q, m_valid_d;
  result_t            m_res_q, m_res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mask_q <= HASH_MASK_RESET;
    end else if (cfg_valid_i) begin
      hash_mask_q <= cfg_data_i;
    end
  end

  assign in_item.kind        = kind_e'(s_axis_tuser);
  assign in_item.space_id    = s_axis_tdata[SPACE_ID_W-1:0];
  assign in_item.virt_addr   = s_axis_tdata[SPACE_ID_W +: VA_W];
  assign in_item.phys_word   = s_axis_tdata[SPACE_ID_W+VA_W +: PHYS_W];
  assign in_item.sweep_color = s_axis_tdata[SPACE_ID_W+VA_W+PHYS_W +: COLOR_W];

  hpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hash_mask_i (hash_mask_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  hpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_res_d   = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, m_res_q.purge_total,
                          m_res_q.tlb_flush, m_res_q.slot, m_res_q.group_index,
                          m_res_q.status};

`include "hashed_page_table_insert_sweep_assert.svh"

  `HPT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
  `HPT_ASSERT_IMPLIES(a_idle_no_write, s_axis_tready, !mem_req.we)
  `HPT_ASSERT_IMPLIES(a_idle_no_result, s_axis_tready, !res_valid)
  `HPT_ASSERT_IMPLIES(a_no_table_result, res_valid && (res.status == ST_SWEEP || res.status == ST_REJECT), !res.tlb_flush && res.slot == '0 && res.group_index == '0)

endmodule

>>> verif/hashed_page_table_insert_sweep_tb.sv
// Self-checking bench for the hashed page table insert and color sweep block.
// Scoreboard class predicts every result; needs hpt_pkg and the top level only.
`timescale 1ns / 1ps

module hashed_page_table_insert_sweep_tb;
  import hpt_pkg::*;

  class hpt_scoreboard;
    bit [WORD_W-1:0]  pte_hi [NUM_ENTRIES];
    bit [WORD_W-1:0]  pte_lo [NUM_ENTRIES];
    bit [SLOT_W-1:0]  victim_ptr;
    bit [PURGE_W-1:0] purge_cnt;
    bit [GROUP_W-1:0] hash_mask;
    result_t          expected_q[$];
    int unsigned      mismatch_cnt;
    int unsigned      status_cnt[5];

    function new();
      foreach (pte_hi[i]) begin
        pte_hi[i] = '0;
        pte_lo[i] = '0;
      end
      victim_ptr   = '0;
      purge_cnt    = '0;
      hash_mask    = HASH_MASK_RESET;
      mismatch_cnt = 0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
    endfunction

    function void note_item(item_t it);
      result_t          r;
      bit [23:0]        vsid;
      bit [WORD_W-1:0]  hi;
      bit [GROUP_W-1:0] grp;
      int unsigned      base;
      int unsigned      slot;
      bit               found;
      bit               matched;
      r = '0;
      if (it.kind == KIND_SWEEP) begin
        foreach (pte_hi[i]) begin
          if (pte_hi[i][31:29] == {1'b1, it.sweep_color}) pte_hi[i] = '0;
        end
        r.status = ST_SWEEP;
      end else if (it.space_id == '0) begin
        r.status = ST_REJECT;
      end else begin
        vsid    = {it.space_id, 3'b000} | {20'd0, it.virt_addr[31:28]};
        hi      = {1'b1, vsid, 1'b0, it.virt_addr[27:22]};
        grp     = (vsid[9:0] ^ it.virt_addr[21:12]) & hash_mask & GROUP_MASK;
        base    = grp * SLOTS_PER_GROUP;
        found   = 1'b0;
        matched = 1'b0;
        slot    = 0;
        for (int s = 0; s < SLOTS_PER_GROUP && !matched; s++) begin
          if (pte_hi[base + s] == hi) begin
            slot    = s;
            found   = 1'b1;
            matched = 1'b1;
          end else if (!found && !pte_hi[base + s][31]) begin
            slot  = s;
            found = 1'b1;
          end
        end
        if (matched) begin
          r.status = ST_MATCHED;
        end else if (found) begin
          r.status = ST_FREE;
        end else begin
          slot = victim_ptr;
          victim_ptr++;
          r.status = ST_VICTIM;
        end
        if (pte_hi[base + slot] != hi || pte_lo[base + slot] != it.phys_word) begin
          r.tlb_flush = 1'b1;
          purge_cnt++;
        end
        pte_hi[base + slot] = hi;
        pte_lo[base + slot] = it.phys_word;
        r.group_index = grp;
        r.slot        = slot[SLOT_W-1:0];
      end
      r.purge_total = purge_cnt;
      status_cnt[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
      result_t want;
      result_t got;
      got.status      = status_e'(d[2:0]);
      got.group_index = d[12:3];
      got.slot        = d[15:13];
      got.tlb_flush   = d[16];
      got.purge_total = d[48:17];
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d group %0d slot %0d flush %0d purge %0d",
                   got.status, got.group_index, got.slot, got.tlb_flush, got.purge_total);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.group_index !== want.group_index ||
          got.slot !== want.slot || got.tlb_flush !== want.tlb_flush ||
          got.purge_total !== want.purge_total) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("mismatch at %0t: expected status %0d group %0d slot %0d flush %0d purge %0d",
                   $realtime, want.status, want.group_index, want.slot, want.tlb_flush,
                   want.purge_total);
          $display("                actual status %0d group %0d slot %0d flush %0d purge %0d",
                   got.status, got.group_index, got.slot, got.tlb_flush, got.purge_total);
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [GROUP_W-1:0]     cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  hpt_scoreboard sb;
  item_t         recent_q[$];
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  logic          long_hold_arm  = 1'b0;
  logic          long_hold_done = 1'b0;
  int            hold_left      = 0;

  hashed_page_table_insert_sweep u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receive side: check each accepted transaction, then pick the next tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (long_hold_arm && !long_hold_done) begin
        hold_left      <= 400;
        long_hold_done <= 1'b1;
        m_axis_tready  <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic item_t mk_item(kind_e kind, logic [SPACE_ID_W-1:0] sid,
                                    logic [VA_W-1:0] va, logic [PHYS_W-1:0] pa,
                                    logic [COLOR_W-1:0] color);
    item_t it;
    it.kind        = kind;
    it.space_id    = sid;
    it.virt_addr   = va;
    it.phys_word   = pa;
    it.sweep_color = color;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(999);
    it   = mk_item(KIND_INSERT, SPACE_ID_W'($urandom_range(2097151, 1)), $urandom,
                   $urandom, COLOR_W'($urandom_range(3)));
    if (pick < 7) begin
      it.kind = KIND_SWEEP;
    end else if (pick < 27) begin
      it.space_id = '0;
    end else if (pick < 400 && recent_q.size() > 0) begin
      it.space_id  = recent_q[$urandom_range(recent_q.size() - 1)].space_id;
      it           = recent_q[$urandom_range(recent_q.size() - 1)];
      it.kind      = KIND_INSERT;
      it.sweep_color = COLOR_W'($urandom_range(3));
      if ($urandom_range(1)) it.phys_word = $urandom;
    end else begin
      // crowd a few groups so that victims and matches come often
      if (pick < 700) begin
        it.space_id  = {2'($urandom_range(3)), 15'd0, 4'($urandom_range(15))};
        it.virt_addr = {4'($urandom_range(15)), 6'($urandom_range(63)), 6'd0,
                        4'($urandom_range(3)), 12'($urandom)};
      end
      recent_q.push_back(it);
      if (recent_q.size() > 64) void'(recent_q.pop_front());
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= S_TDATA_W'({it.sweep_color, it.phys_word, it.virt_addr, it.space_id});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_mask(input logic [GROUP_W-1:0] m);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.hash_mask = m;
  endtask

  task automatic run_directed();
    send_item(mk_item(KIND_INSERT, '0, 32'h1234_5678, 32'h9abc_def0, 2'd1));
    send_item(mk_item(KIND_INSERT, '0, '1, '1, 2'd3));
    send_item(mk_item(KIND_INSERT, 21'd1, '0, '0, 2'd0));
    send_item(mk_item(KIND_INSERT, 21'd1, '0, '0, 2'd2));
    send_item(mk_item(KIND_INSERT, 21'd1, '0, '1, 2'd0));
    send_item(mk_item(KIND_INSERT, '1, '1, '1, 2'd3));
    // nine ids hashing into group 0, which already holds one entry: seven free slots, then two victims
    for (int k = 1; k <= 9; k++)
      send_item(mk_item(KIND_INSERT, SPACE_ID_W'(128 * k), '0, 32'(k), 2'd0));
    send_item(mk_item(KIND_SWEEP, 21'h0AAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 2'd0));
    send_item(mk_item(KIND_INSERT, 21'd256, '0, 32'd2, 2'd0));
    send_item(mk_item(KIND_SWEEP, '1, '1, '1, 2'd3));
    send_item(mk_item(KIND_INSERT, 21'h080005, 32'h3000_0000, 32'h11, 2'd0));
    send_item(mk_item(KIND_INSERT, 21'h100003, 32'h7fc0_1000, 32'h22, 2'd0));
    send_item(mk_item(KIND_SWEEP, '0, '0, '0, 2'd1));
    send_item(mk_item(KIND_INSERT, 21'h080005, 32'h3000_0000, 32'h11, 2'd0));
    send_item(mk_item(KIND_SWEEP, 21'h1, 32'h1, 32'h1, 2'd2));
  endtask

  task automatic run_random(input int n, input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) long_hold_arm <= 1'b1;
      if (i == pause_at) drain();
      send_item(rand_item());
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain();

    write_mask('0);
    run_random(340, 100, -1);
    drain();

    write_mask(10'd1023);
    send_idle_pct <= 56;
    run_random(500, -1, -1);
    drain();

    write_mask(10'd7);
    send_idle_pct  <= 0;
    recv_stall_pct <= 56;
    run_random(500, -1, 200);
    drain();

    write_mask(10'd63);
    send_idle_pct  <= 16;
    recv_stall_pct <= 16;
    run_random(490, -1, -1);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d inserts (%0d matched, %0d free slot, %0d victim), %0d sweeps, %0d zero ids",
             sb.status_cnt[ST_MATCHED] + sb.status_cnt[ST_FREE] + sb.status_cnt[ST_VICTIM],
             sb.status_cnt[ST_MATCHED], sb.status_cnt[ST_FREE], sb.status_cnt[ST_VICTIM],
             sb.status_cnt[ST_SWEEP], sb.status_cnt[ST_REJECT]);
    $display("Hash masks 1023, 0, 7 and 63 with idle and stall mixes on both stream sides");
    if (sb.mismatch_cnt == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_ram.sv
rtl/core/hpt_ctrl.sv
rtl/core/hashed_page_table_insert_sweep.sv
verif/hashed_page_table_insert_sweep_tb.sv
